FILE: design/mk_pkg.sv
// Package with the Morse code tables, character codes and shared types of the keyer.
package mk_pkg;

  localparam int MAX_CODE_SLOTS = 7;
  localparam int PAT_W = MAX_CODE_SLOTS - 1;
  localparam int CNT_W = $clog2(MAX_CODE_SLOTS);

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LOWER_LO = 8'd97;
  localparam logic [7:0] CH_LOWER_HI = 8'd122;
  localparam logic [7:0] CH_CASE_DIFF = 8'd32;
  localparam logic [7:0] CH_A = 8'h41;
  localparam logic [7:0] CH_Z = 8'h5A;
  localparam logic [7:0] CH_0 = 8'h30;
  localparam logic [7:0] CH_9 = 8'h39;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_EQUAL = 8'h3D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  localparam logic [0:0] REG_DOT_TIME = 1'b0;
  localparam logic [0:0] REG_TX_ENABLE = 1'b1;

  localparam logic [15:0] DOT_TIME_RESET = 16'd40;

  localparam logic [2:0] UNITS_DIT = 3'd1;
  localparam logic [2:0] UNITS_GAP = 3'd2;
  localparam logic [2:0] UNITS_DAH = 3'd3;
  localparam logic [2:0] UNITS_SPACE = 3'd6;

  localparam logic [CNT_W-1:0] LETTER_LEN [26] = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
    3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
  };

  localparam logic [PAT_W-1:0] LETTER_PAT [26] = '{
    6'd1, 6'd8, 6'd10, 6'd4, 6'd0, 6'd2, 6'd6, 6'd0, 6'd0, 6'd7, 6'd5, 6'd4, 6'd3,
    6'd2, 6'd7, 6'd6, 6'd13, 6'd2, 6'd0, 6'd1, 6'd1, 6'd1, 6'd3, 6'd9, 6'd11, 6'd12
  };

  localparam logic [PAT_W-1:0] DIGIT_PAT [10] = '{
    6'd31, 6'd15, 6'd7, 6'd3, 6'd1, 6'd0, 6'd16, 6'd24, 6'd28, 6'd30
  };

  typedef struct packed {
    logic             hit;
    logic [CNT_W-1:0] len;
    logic [PAT_W-1:0] pat;
  } code_t;

  // Looks up an upper-case character; the pattern comes back left-aligned, 1 = dah.
  function automatic code_t lookup(input logic [7:0] c);
    code_t            res;
    logic [7:0]       ofs_l;
    logic [7:0]       ofs_d;
    logic [PAT_W-1:0] raw;
    ofs_l = c - CH_A;
    ofs_d = c - CH_0;
    res.hit = 1'b1;
    res.len = CNT_W'(5);
    raw = '0;
    if (c >= CH_A && c <= CH_Z) begin
      res.len = LETTER_LEN[ofs_l[4:0]];
      raw = LETTER_PAT[ofs_l[4:0]];
    end else if (c >= CH_0 && c <= CH_9) begin
      raw = DIGIT_PAT[ofs_d[3:0]];
    end else if (c == CH_QUEST) begin
      res.len = CNT_W'(6);
      raw = PAT_W'(12);
    end else if (c == CH_EQUAL) begin
      raw = PAT_W'(17);
    end else if (c == CH_COMMA) begin
      res.len = CNT_W'(6);
      raw = PAT_W'(51);
    end else if (c == CH_SLASH) begin
      raw = PAT_W'(18);
    end else begin
      res.hit = 1'b0;
      res.len = '0;
    end
    res.pat = raw << (CNT_W'(PAT_W) - res.len);
    return res;
  endfunction

endpackage

FILE: design/morse_keyer.sv
// Morse keyer top level: character input, segment sequencer and registered segment output.
//
// The block takes one ASCII character on the char channel (char_valid, char_stall,
// char_code) and sends out keying segments on the seg channel (seg_valid, seg_stall
// and the segment fields). Lower-case letters are folded to upper case. A space gives
// one key-off segment of six dots; a known character gives an on segment and a one-dot
// off segment per element, then a two-dot closing gap; anything else gives no segment.
// The pattern of a character is held in a shift register and one element is shifted
// out per on/off pair. After a character is accepted the sequencer enters its first
// state, which then loads the first segment into the output register. A new character
// is taken once the last segment of the previous one is in the output register.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes the dot
// time at index 0 and the transmitter enable at index 1; it is always ready. The user
// must write it only while the keyer is idle; the block does not enforce this. Reset
// is synchronous and restores a dot time of 40 ticks with the transmitter enabled, and
// empties the sequencer and output register. While seg_stall is high the shown segment
// holds and the sequencer waits to emit its next segment.
module morse_keyer
  import mk_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        char_valid,
  output logic        char_stall,
  input  logic [7:0]  char_code,
  output logic        seg_valid,
  input  logic        seg_stall,
  output logic        key_on,
  output logic        tx_on,
  output logic [2:0]  length_units,
  output logic [18:0] length_ticks,
  output logic        end_of_char,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ON    = 5'b00010,
    S_OFF   = 5'b00100,
    S_GAP   = 5'b01000,
    S_SPACE = 5'b10000
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [15:0]      dot_time;
  logic             tx_enable;
  logic [PAT_W-1:0] pat;
  logic [PAT_W-1:0] pat_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic [7:0]       folded;
  code_t            code;
  logic             out_free;
  logic             emit;
  logic             emit_on;
  logic             emit_last;
  logic [2:0]       emit_units;
  logic [18:0]      dot1;
  logic [18:0]      dot2;
  logic [18:0]      emit_ticks;

  assign cfg_ready = 1'b1;
  assign char_stall = (state != S_IDLE);
  assign out_free = !seg_valid || !seg_stall;

  always_comb begin
    folded = char_code;
    if (char_code >= CH_LOWER_LO && char_code <= CH_LOWER_HI) begin
      folded = char_code - CH_CASE_DIFF;
    end
    code = lookup(folded);
  end

  always_comb begin
    state_next = state;
    pat_next = pat;
    cnt_next = cnt;
    emit = 1'b0;
    emit_on = 1'b0;
    emit_last = 1'b0;
    emit_units = UNITS_DIT;
    unique case (state)
      S_IDLE: begin
        if (char_valid) begin
          if (char_code == CH_SPACE) begin
            state_next = S_SPACE;
          end else if (code.hit) begin
            state_next = S_ON;
            pat_next = code.pat;
            cnt_next = code.len;
          end
        end
      end
      S_ON: begin
        emit = out_free;
        emit_on = 1'b1;
        emit_units = pat[PAT_W-1] ? UNITS_DAH : UNITS_DIT;
        if (out_free) begin
          pat_next = {pat[PAT_W-2:0], 1'b0};
          cnt_next = cnt - 1'b1;
          state_next = S_OFF;
        end
      end
      S_OFF: begin
        emit = out_free;
        if (out_free) begin
          state_next = (cnt == '0) ? S_GAP : S_ON;
        end
      end
      S_GAP: begin
        emit = out_free;
        emit_units = UNITS_GAP;
        emit_last = 1'b1;
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      S_SPACE: begin
        emit = out_free;
        emit_units = UNITS_SPACE;
        emit_last = 1'b1;
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    dot1 = {3'b000, dot_time};
    dot2 = {2'b00, dot_time, 1'b0};
    unique case (emit_units)
      UNITS_DIT:   emit_ticks = dot1;
      UNITS_GAP:   emit_ticks = dot2;
      UNITS_DAH:   emit_ticks = dot1 + dot2;
      UNITS_SPACE: emit_ticks = {dot1[17:0], 1'b0} + {dot2[17:0], 1'b0};
      default:     emit_ticks = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      seg_valid <= 1'b0;
      dot_time <= DOT_TIME_RESET;
      tx_enable <= 1'b1;
    end else begin
      state <= state_next;
      if (emit) begin
        seg_valid <= 1'b1;
      end else if (!seg_stall) begin
        seg_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_DOT_TIME:  dot_time <= cfg_data;
          REG_TX_ENABLE: tx_enable <= cfg_data[0];
          default:       dot_time <= dot_time;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    pat <= pat_next;
    cnt <= cnt_next;
    if (emit) begin
      key_on <= emit_on;
      tx_on <= emit_on & tx_enable;
      length_units <= emit_units;
      length_ticks <= emit_ticks;
      end_of_char <= emit_last;
    end
  end

endmodule

FILE: tb/morse_keyer_tb.sv
// Self-checking testbench for the Morse keyer: directed and random characters checked per segment.
module morse_keyer_tb
  import mk_pkg::*;
;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 20;
  localparam byte DAH_MARK = "-";

  typedef struct packed {
    logic        key;
    logic        tx;
    logic [2:0]  units;
    logic [18:0] ticks;
    logic        last;
  } seg_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        char_valid = 1'b0;
  logic        char_stall;
  logic [7:0]  char_code = '0;
  logic        seg_valid;
  logic        seg_stall = 1'b0;
  logic        key_on;
  logic        tx_on;
  logic [2:0]  length_units;
  logic [18:0] length_ticks;
  logic        end_of_char;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  logic [15:0] dot_time_q = DOT_TIME_RESET;
  logic        tx_enable_q = 1'b1;
  seg_t        pending_segs [$];
  int          snd_idle_pct = 0;
  int          rcv_idle_pct = 0;
  int          errors = 0;
  int          chars_sent = 0;
  int          segs_checked = 0;
  int          cfg_writes = 0;
  int          cycles = 0;

  string letter_morse [26] = '{
    ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---", "-.-", ".-..", "--",
    "-.", "---", ".--.", "--.-", ".-.", "...", "-", "..-", "...-", ".--", "-..-", "-.--", "--.."
  };
  string digit_morse [10] = '{
    "-----", ".----", "..---", "...--", "....-", ".....", "-....", "--...", "---..", "----."
  };

  morse_keyer u_top (
    .clk(clk), .rst(rst),
    .char_valid(char_valid), .char_stall(char_stall), .char_code(char_code),
    .seg_valid(seg_valid), .seg_stall(seg_stall),
    .key_on(key_on), .tx_on(tx_on), .length_units(length_units),
    .length_ticks(length_ticks), .end_of_char(end_of_char),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(negedge clk) seg_stall <= ($urandom_range(99) < rcv_idle_pct);

  always @(posedge clk) begin
    seg_t got;
    seg_t want;
    if (!rst && seg_valid && !seg_stall) begin
      got = '{key_on, tx_on, length_units, length_ticks, end_of_char};
      if (pending_segs.size() == 0) begin
        errors++;
        $display("%0t: unexpected segment: key=%0d tx=%0d units=%0d ticks=%0d end=%0d",
                 $time, got.key, got.tx, got.units, got.ticks, got.last);
      end else begin
        want = pending_segs.pop_front();
        segs_checked++;
        if (got !== want) begin
          errors++;
          $display("%0t: segment mismatch: expected key=%0d tx=%0d units=%0d ticks=%0d end=%0d",
                   $time, want.key, want.tx, want.units, want.ticks, want.last);
          $display("%0t:                   actual key=%0d tx=%0d units=%0d ticks=%0d end=%0d",
                   $time, got.key, got.tx, got.units, got.ticks, got.last);
        end
      end
    end
  end

  function automatic string morse_of(input logic [7:0] c);
    if (c >= CH_A && c <= CH_Z) return letter_morse[c - CH_A];
    if (c >= CH_0 && c <= CH_9) return digit_morse[c - CH_0];
    case (c)
      CH_QUEST: return "..--..";
      CH_EQUAL: return "-...-";
      CH_COMMA: return "--..--";
      CH_SLASH: return "-..-.";
      default: return "";
    endcase
  endfunction

  function automatic void push_seg(input logic on, input logic [2:0] units, input logic last);
    pending_segs.push_back('{on, on & tx_enable_q, units, 19'(units) * 19'(dot_time_q), last});
  endfunction

  function automatic void encode_char(input logic [7:0] code);
    logic [7:0] c;
    string      elems;
    c = code;
    if (c == CH_SPACE) begin
      push_seg(1'b0, UNITS_SPACE, 1'b1);
      return;
    end
    if (c >= CH_LOWER_LO && c <= CH_LOWER_HI) c = c - CH_CASE_DIFF;
    elems = morse_of(c);
    if (elems.len() == 0) return;
    for (int i = 0; i < elems.len(); i++) begin
      push_seg(1'b1, (elems[i] == DAH_MARK) ? UNITS_DAH : UNITS_DIT, 1'b0);
      push_seg(1'b0, UNITS_DIT, 1'b0);
    end
    push_seg(1'b0, UNITS_GAP, 1'b1);
  endfunction

  task automatic send_char(input logic [7:0] code);
    @(negedge clk);
    while ($urandom_range(99) < snd_idle_pct) begin
      char_valid <= 1'b0;
      @(negedge clk);
    end
    char_valid <= 1'b1;
    char_code <= code;
    do @(posedge clk); while (!(char_valid && !char_stall));
    encode_char(code);
    chars_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    char_valid <= 1'b0;
    while (pending_segs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [15:0] data);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    if (idx == REG_DOT_TIME) dot_time_q = data;
    else tx_enable_q = data[0];
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] pick_char();
    case ($urandom_range(9))
      0, 1, 2: return CH_A + 8'($urandom_range(25));
      3, 4:    return CH_LOWER_LO + 8'($urandom_range(25));
      5:       return CH_0 + 8'($urandom_range(9));
      6: begin
        case ($urandom_range(3))
          0: return CH_QUEST;
          1: return CH_EQUAL;
          2: return CH_COMMA;
          default: return CH_SLASH;
        endcase
      end
      7:       return CH_SPACE;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic test_reset_defaults();
    logic [7:0] codes [8];
    codes = '{CH_A + 8'd4, CH_A + 8'd19, CH_0, CH_9, CH_QUEST, CH_COMMA, CH_SPACE, CH_Z};
    foreach (codes[i]) send_char(codes[i]);
    wait_idle();
  endtask

  task automatic test_short_dot_tx_off();
    logic [7:0] codes [9];
    codes = '{8'h00, 8'hFF, 8'h80, 8'h7F, CH_LOWER_LO, CH_LOWER_HI,
              CH_LOWER_LO - 8'd1, CH_LOWER_HI + 8'd1, CH_EQUAL};
    write_reg(REG_DOT_TIME, 16'd1);
    write_reg(REG_TX_ENABLE, 16'd0);
    foreach (codes[i]) send_char(codes[i]);
    wait_idle();
  endtask

  task automatic test_long_dot_tx_on();
    logic [7:0] codes [7];
    codes = '{CH_SLASH, CH_A - 8'd1, CH_Z + 8'd1, CH_9 + 8'd1, CH_A, CH_SPACE, CH_A + 8'd16};
    write_reg(REG_DOT_TIME, 16'hFFFF);
    write_reg(REG_TX_ENABLE, 16'd1);
    foreach (codes[i]) send_char(codes[i]);
    wait_idle();
  endtask

  task automatic test_random_text(input int snd_pct, input int rcv_pct, input int count);
    write_reg(REG_DOT_TIME, 16'($urandom_range(65535, 1)));
    write_reg(REG_TX_ENABLE, 16'($urandom_range(1)));
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    for (int i = 0; i < count; i++) begin
      send_char(pick_char());
      if (i == count / 2) wait_idle();
    end
    wait_idle();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_short_dot_tx_off();
    test_long_dot_tx_on();
    test_random_text(6, 57, 36);
    test_random_text(57, 6, 36);
    test_random_text(0, 0, 36);
    $display("Run covered %0d characters and %0d checked segments over %0d register writes,",
             chars_sent, segs_checked, cfg_writes);
    $display("including dot time extremes, gated transmitter and unknown codes.");
    if (errors == 0 && pending_segs.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d errors, %0d segments never seen", errors, pending_segs.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
